// File: hdl/gdsu_pkg.sv
// Package: shared types, codes and calendar helpers for the date subtract unit
`timescale 1ns / 1ps
package gdsu_pkg;

  localparam logic [1:0] CMD_DAYS   = 2'd0;
  localparam logic [1:0] CMD_WEEKS  = 2'd1;
  localparam logic [1:0] CMD_MONTHS = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_UNDER   = 2'd2;

  localparam logic [17:0] D400 = 18'd146097;
  localparam logic [17:0] D100 = 18'd36524;
  localparam logic [17:0] D4   = 18'd1461;
  localparam logic [17:0] D1   = 18'd365;

  // reciprocals: /100 and /12 exact over their ranges, the day-cycle ones low by at most one
  localparam logic [13:0] RECIP_100  = 14'd10486;
  localparam logic [15:0] RECIP_12   = 16'd43691;
  localparam logic [9:0]  RECIP_D400 = 10'd918;
  localparam logic [8:0]  RECIP_D100 = 9'd459;
  localparam logic [10:0] RECIP_D4   = 11'd1435;

  localparam int unsigned CARRY_DEPTH = 7;

  // cumulative days before month m (non-leap), index 1..12
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    case (m)
      4'd1:  cum_days = 9'd0;
      4'd2:  cum_days = 9'd31;
      4'd3:  cum_days = 9'd59;
      4'd4:  cum_days = 9'd90;
      4'd5:  cum_days = 9'd120;
      4'd6:  cum_days = 9'd151;
      4'd7:  cum_days = 9'd181;
      4'd8:  cum_days = 9'd212;
      4'd9:  cum_days = 9'd243;
      4'd10: cum_days = 9'd273;
      4'd11: cum_days = 9'd304;
      4'd12: cum_days = 9'd334;
      default: cum_days = 9'd0;
    endcase
  endfunction

  // leap test; the century quotient comes from a reciprocal multiply
  function automatic logic is_leap(input logic [13:0] y);
    logic [27:0] prod;
    logic [7:0]  q100;
    prod    = 28'(y) * 28'(RECIP_100);
    q100    = 8'(prod >> 20);
    is_leap = (y[1:0] == 2'd0) &&
              (((14'(q100) * 14'd100) != y) || (q100[1:0] == 2'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    case (m)
      4'd2: month_len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
      default: month_len = 5'd31;
    endcase
  endfunction

  typedef struct packed {
    logic        valid;
    logic [1:0]  cmd;
    logic [4:0]  day;
    logic [3:0]  mon;
    logic [13:0] yr;
    logic [15:0] amt;
    logic [1:0]  st;
  } front_t;

  typedef struct packed {
    front_t      f;
    logic [4:0]  md;
    logic [3:0]  mm;
    logic [13:0] my;
  } carry_t;

  typedef struct packed {
    logic        valid;
    logic [4:0]  day;
    logic [3:0]  mon;
    logic [13:0] yr;
    logic [1:0]  st;
  } res_t;

endpackage

// File: hdl/gdsu_front.sv
// Front stages: input check, day-number conversion and subtraction for all commands
`timescale 1ns / 1ps
module gdsu_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               in_valid_i,
  input  logic [1:0]         cmd_i,
  input  logic [4:0]         day_i,
  input  logic [3:0]         mon_i,
  input  logic [13:0]        yr_i,
  input  logic [15:0]        amt_i,
  output gdsu_pkg::front_t   f_o,
  output logic [21:0]        ord_o,
  output logic [4:0]         mday_o,
  output logic [3:0]         mmon_o,
  output logic [13:0]        myr_o
);
  import gdsu_pkg::*;

  // stage 1: validate, year part of ordinal, scale weeks to days, split amount into years and months
  front_t      s1_d, s1_q;
  logic [21:0] ybase_d, ybase_q;
  logic [18:0] sub_d, sub_q;
  logic        leap1_d, leap1_q;
  logic [12:0] aq_d, aq_q;
  logic [3:0]  ar_d, ar_q;
  logic [13:0] p;
  logic [27:0] pprod;
  logic [7:0]  pq100;
  logic [31:0] aprod;

  always_comb begin
    p       = yr_i - 14'd1;
    pprod   = 28'(p) * 28'(RECIP_100);
    pq100   = 8'(pprod >> 20);
    leap1_d = is_leap(yr_i);
    ybase_d = 22'(p) * 22'd365 + 22'(p >> 2) - 22'(pq100) + 22'(pq100 >> 2);
    sub_d   = (cmd_i == CMD_WEEKS) ? 19'(amt_i) * 19'd7 : 19'(amt_i);
    aprod   = 32'(amt_i) * 32'(RECIP_12);
    aq_d    = 13'(aprod >> 19);
    ar_d    = 4'(amt_i - 16'(aq_d) * 16'd12);
    s1_d.valid = in_valid_i;
    s1_d.cmd = cmd_i;
    s1_d.day = day_i;
    s1_d.mon = mon_i;
    s1_d.yr  = yr_i;
    s1_d.amt = amt_i;
    if (mon_i < 4'd1 || mon_i > 4'd12 || yr_i < 14'd1 || yr_i > 14'd9999 || day_i < 5'd1 ||
        day_i > month_len(mon_i, leap1_d))
      s1_d.st = ST_INVALID;
    else
      s1_d.st = ST_OK;
  end

  // stage 2: finish ordinal, month subtraction with borrow
  front_t      s2_d, s2_q;
  logic [21:0] ord_d, ord_q;
  logic [18:0] sub2_q;
  logic [3:0]  m0;
  logic        mbor;
  logic [14:0] ydiff;
  logic        mund_d, mund_q;
  logic [3:0]  mm2_d, mm2_q;
  logic [13:0] my2_d, my2_q;

  always_comb begin
    s2_d   = s1_q;
    ord_d  = ybase_q + 22'(cum_days(s1_q.mon)) +
             ((leap1_q && s1_q.mon > 4'd2) ? 22'd1 : 22'd0) + 22'(s1_q.day);
    m0     = s1_q.mon - 4'd1;
    mbor   = m0 < ar_q;
    mm2_d  = (mbor ? (m0 + 4'd12 - ar_q) : (m0 - ar_q)) + 4'd1;
    ydiff  = 15'(s1_q.yr) - 15'(aq_q) - 15'(mbor);
    mund_d = ydiff[14] || (ydiff == 15'd0);
    my2_d  = ydiff[13:0];
  end

  // stage 3: day subtraction, day clamp and underflow check
  logic [21:0] nd_d, nd_q;
  logic        ok_d;
  logic [4:0]  md_d, md_q;
  logic [3:0]  mm_q;
  logic [13:0] my_q;
  front_t      s3_d, s3_q;
  logic [4:0]  ml;

  always_comb begin
    s3_d = s2_q;
    ok_d = 22'(sub2_q) < ord_q;
    nd_d = ord_q - 22'(sub2_q) - 22'd1;
    ml   = month_len(mm2_q, is_leap(my2_q));
    md_d = (s2_q.day > ml) ? ml : s2_q.day;
    if (s2_q.st == ST_OK) begin
      case (s2_q.cmd)
        CMD_DAYS, CMD_WEEKS: if (!ok_d) s3_d.st = ST_UNDER;
        CMD_MONTHS: if (mund_q) s3_d.st = ST_UNDER;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q    <= '0;
      s2_q    <= '0;
      s3_q    <= '0;
      ybase_q <= '0;
      sub_q   <= '0;
      leap1_q <= 1'b0;
      aq_q    <= '0;
      ar_q    <= '0;
      ord_q   <= '0;
      sub2_q  <= '0;
      mund_q  <= 1'b0;
      mm2_q   <= '0;
      my2_q   <= '0;
      nd_q    <= '0;
      md_q    <= '0;
      mm_q    <= '0;
      my_q    <= '0;
    end else if (adv_i) begin
      s1_q    <= s1_d;
      s2_q    <= s2_d;
      s3_q    <= s3_d;
      ybase_q <= ybase_d;
      sub_q   <= sub_d;
      leap1_q <= leap1_d;
      aq_q    <= aq_d;
      ar_q    <= ar_d;
      ord_q   <= ord_d;
      sub2_q  <= sub_q;
      mund_q  <= mund_d;
      mm2_q   <= mm2_d;
      my2_q   <= my2_d;
      nd_q    <= nd_d;
      md_q    <= md_d;
      mm_q    <= mm2_q;
      my_q    <= my2_q;
    end
  end

  assign f_o    = s3_q;
  assign ord_o  = nd_q;
  assign mday_o = md_q;
  assign mmon_o = mm_q;
  assign myr_o  = my_q;
endmodule

// File: hdl/gdsu_back.sv
// Back stages: day number back to a calendar date and result selection
`timescale 1ns / 1ps
module gdsu_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  gdsu_pkg::front_t   f_i,
  input  logic [21:0]        ord_i,
  input  logic [4:0]         mday_i,
  input  logic [3:0]         mmon_i,
  input  logic [13:0]        myr_i,
  output gdsu_pkg::res_t     r_o
);
  import gdsu_pkg::*;

  carry_t      cin;
  carry_t      c_q [CARRY_DEPTH];

  assign cin = {f_i, mday_i, mmon_i, myr_i};

  // stage 4: 400 year estimate
  logic [21:0] aord_q;
  logic [31:0] p400;
  logic [5:0]  q400e_d, q400e_q;

  always_comb begin
    p400    = 32'(ord_i) * 32'(RECIP_D400);
    q400e_d = 6'(p400 >> 27);
  end

  // stage 5: 400 year correction
  logic [22:0] r4w;
  logic        fix400;
  logic [5:0]  q400;
  logic [17:0] r4_d, r4_q;
  logic [13:0] y5_d, y5_q;

  always_comb begin
    r4w    = 23'(aord_q) - 23'(q400e_q) * 23'(D400);
    fix400 = r4w >= 23'(D400);
    q400   = q400e_q + 6'(fix400);
    r4_d   = fix400 ? 18'(r4w - 23'(D400)) : 18'(r4w);
    y5_d   = 14'(q400) * 14'd400;
  end

  // stage 6: 100 year estimate
  logic [17:0] r4b_q;
  logic [13:0] y6_q;
  logic [27:0] p100;
  logic [2:0]  q100e_d, q100e_q;

  always_comb begin
    p100    = 28'(r4_q) * 28'(RECIP_D100);
    q100e_d = 3'(p100 >> 24);
  end

  // stage 7: 100 year correction and clamp
  logic [17:0] rr;
  logic        fix100;
  logic [1:0]  q100;
  logic [15:0] r100_d, r100_q;
  logic [13:0] y7_d, y7_q;

  always_comb begin
    rr     = r4b_q - 18'(q100e_q) * D100;
    fix100 = (rr >= D100) && (q100e_q < 3'd3);
    q100   = q100e_q[1:0] + 2'(fix100);
    r100_d = fix100 ? 16'(rr - D100) : 16'(rr);
    y7_d   = y6_q + 14'(q100) * 14'd100;
  end

  // stage 8: 4 year estimate
  logic [15:0] r100b_q;
  logic [13:0] y8_q;
  logic [26:0] p4;
  logic [4:0]  q4e_d, q4e_q;

  always_comb begin
    p4    = 27'(r100_q) * 27'(RECIP_D4);
    q4e_d = 5'(p4 >> 21);
  end

  // stage 9: 4 year correction
  logic [15:0] r1w;
  logic        fix4;
  logic [4:0]  q4;
  logic [10:0] r1_d, r1_q;
  logic [13:0] y9_d, y9_q;

  always_comb begin
    r1w  = r100b_q - 16'(q4e_q) * 16'(D4);
    fix4 = r1w >= 16'(D4);
    q4   = q4e_q + 5'(fix4);
    r1_d = fix4 ? 11'(r1w - 16'(D4)) : 11'(r1w);
    y9_d = y8_q + 14'(q4) * 14'd4;
  end

  // stage 10: single year
  logic [1:0]  q1;
  logic [8:0]  doy_d, doy_q;
  logic [13:0] y_d, y_q;

  always_comb begin
    if (r1_q >= 11'(D1) * 11'd3)
      q1 = 2'd3;
    else if (r1_q >= 11'(D1) * 11'd2)
      q1 = 2'd2;
    else if (r1_q >= 11'(D1))
      q1 = 2'd1;
    else
      q1 = 2'd0;
    doy_d = 9'(r1_q - 11'(q1) * 11'(D1));
    y_d   = y9_q + 14'(q1) + 14'd1;
  end

  // stage 11: month search and output select
  res_t        r_d, r_q;
  carry_t      cl;
  logic        lp;
  logic [3:0]  mo;
  logic [9:0]  c;

  always_comb begin
    cl = c_q[CARRY_DEPTH-1];
    lp = is_leap(y_q);
    mo = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      c = 10'(cum_days(4'(k))) + ((lp && k > 2) ? 10'd1 : 10'd0);
      if (10'(doy_q) >= c) mo = 4'(k);
    end
    c = 10'(cum_days(mo)) + ((lp && mo > 4'd2) ? 10'd1 : 10'd0);
    r_d.valid = cl.f.valid;
    r_d.st  = cl.f.st;
    r_d.day = 5'd1;
    r_d.mon = 4'd1;
    r_d.yr  = 14'd1;
    if (cl.f.st == ST_OK) begin
      case (cl.f.cmd)
        CMD_DAYS, CMD_WEEKS: begin
          r_d.day = 5'(10'(doy_q) - c) + 5'd1;
          r_d.mon = mo;
          r_d.yr  = y_q;
        end
        CMD_MONTHS: begin
          r_d.day = cl.md;
          r_d.mon = cl.mm;
          r_d.yr  = cl.my;
        end
        default: begin
          r_d.day = cl.f.day;
          r_d.mon = cl.f.mon;
          r_d.yr  = cl.f.yr;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CARRY_DEPTH; k++) c_q[k] <= '0;
      aord_q  <= '0;
      q400e_q <= '0;
      r4_q    <= '0;
      y5_q    <= '0;
      r4b_q   <= '0;
      y6_q    <= '0;
      q100e_q <= '0;
      r100_q  <= '0;
      y7_q    <= '0;
      r100b_q <= '0;
      y8_q    <= '0;
      q4e_q   <= '0;
      r1_q    <= '0;
      y9_q    <= '0;
      doy_q   <= '0;
      y_q     <= '0;
      r_q     <= '0;
    end else if (adv_i) begin
      c_q[0] <= cin;
      for (int k = 1; k < CARRY_DEPTH; k++) c_q[k] <= c_q[k-1];
      aord_q  <= ord_i;
      q400e_q <= q400e_d;
      r4_q    <= r4_d;
      y5_q    <= y5_d;
      r4b_q   <= r4_q;
      y6_q    <= y5_q;
      q100e_q <= q100e_d;
      r100_q  <= r100_d;
      y7_q    <= y7_d;
      r100b_q <= r100_q;
      y8_q    <= y7_q;
      q4e_q   <= q4e_d;
      r1_q    <= r1_d;
      y9_q    <= y9_d;
      doy_q   <= doy_d;
      y_q     <= y_d;
      r_q     <= r_d;
    end
  end

  assign r_o = r_q;
endmodule

// File: hdl/gregorian_date_subtract_unit.sv
// Top level: pipelined Gregorian date subtraction
// Throughput: one item per cycle; the whole pipeline holds while out_stall_i is high
// and the output register is full.
// Reset: asynchronous active low; clears all pipeline registers, no clearing pass.
`timescale 1ns / 1ps
module gregorian_date_subtract_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [4:0]  start_day_i,
  input  logic [3:0]  start_month_i,
  input  logic [13:0] start_year_i,
  input  logic [15:0] amount_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  result_day_o,
  output logic [3:0]  result_month_o,
  output logic [13:0] result_year_o,
  output logic [1:0]  status_o
);
  import gdsu_pkg::*;

  front_t      f;
  res_t        r;
  logic [21:0] ord;
  logic [4:0]  mday;
  logic [3:0]  mmon;
  logic [13:0] myr;
  logic        adv;

  assign adv = !(r.valid && out_stall_i);
  assign in_stall_o = !adv;

  gdsu_front u_front (
    .clk_i, .rst_ni, .adv_i(adv), .in_valid_i,
    .cmd_i, .day_i(start_day_i), .mon_i(start_month_i), .yr_i(start_year_i),
    .amt_i(amount_i), .f_o(f), .ord_o(ord),
    .mday_o(mday), .mmon_o(mmon), .myr_o(myr)
  );

  gdsu_back u_back (
    .clk_i, .rst_ni, .adv_i(adv), .f_i(f), .ord_i(ord),
    .mday_i(mday), .mmon_i(mmon), .myr_i(myr), .r_o(r)
  );

  assign out_valid_o    = r.valid;
  assign result_day_o   = r.day;
  assign result_month_o = r.mon;
  assign result_year_o  = r.yr;
  assign status_o       = r.st;
endmodule
